// File: sv/rc_pulse_capture_smoother_assert.svh
// Assertion macros for the RC pulse capture smoother.
// Included by the top level; no other dependencies.
`ifndef RC_PULSE_CAPTURE_SMOOTHER_ASSERT_SVH
`define RC_PULSE_CAPTURE_SMOOTHER_ASSERT_SVH

// Same-cycle implication under the active-low reset.
`define RCPS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rcps assertion failed");

// Next-cycle implication under the active-low reset.
`define RCPS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rcps assertion failed");

`endif

// File: sv/rcps_pkg.sv
// Shared types and constants for the RC pulse capture smoother.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rcps_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam int AVG_LEN_DEF  = 4;
    localparam int MAIN_LANES   = 4;

    localparam int PULSE_W    = 12;
    localparam int TIME_W     = 16;
    localparam int PIN_W      = 8;
    localparam int CH_W       = 3;
    localparam int GOOD_W     = 4;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [PULSE_W-1:0] THRESHOLD_RST = 12'd985;
    localparam logic [TIME_W-1:0]  WRAP_RST      = 16'd9999;
    localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 12'd900;
    localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 12'd2200;
    localparam logic [PULSE_W-1:0] WIDTH_RST     = 12'd1500;
    localparam logic [GOOD_W-1:0]  GOOD_ALL      = 4'hF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 4'd0,
        REG_TIMER_WRAP = 4'd1,
        REG_MIN_PULSE = 4'd2,
        REG_MAX_PULSE = 4'd3
    } cfg_reg_e;

    typedef enum logic {
        MODE_SAMPLE = 1'b0,
        MODE_TICK   = 1'b1
    } mode_e;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_UPDATE,
        ST_SETTLE,
        ST_EMIT
    } state_e;

    typedef struct packed {
        logic [PULSE_W-1:0] threshold;
        logic [TIME_W-1:0]  timer_wrap;
        logic [PULSE_W-1:0] min_pulse;
        logic [PULSE_W-1:0] max_pulse;
    } cfg_t;

    typedef struct packed {
        mode_e mode;
        logic  stage_a;
        logic  stage_b;
        logic  stage_c;
        logic  load;
        logic  last;
    } lane_ctl_t;

endpackage

// File: sv/rc_pulse_capture_smoother.sv
// Channel      | Handshake          | Payload
// s_ (input)   | s_tvalid/s_tready  | s_tdata: pin_levels, time_now; s_tuser: mode
// m_ (results) | m_tvalid/m_tready  | m_tdata: channel, smoothed_width, good_mask,
//              |                    |   all_good; m_tlast: last
// cfg_ (regs)  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A pin sample or a compute tick passes through fetch, update, settle and emit before
// the next accept; in emit a tick gives one result per cycle out of the single result
// register; m_tready low holds the emission. The three lane steps (difference or sum,
// window check or reciprocal multiply, deadband update) run in fetch, update and settle.
// Reset is synchronous; state, config and width registers return to their defaults.
// Top level of the RC pulse capture smoother; depends on rcps_pkg, rcps_lane,
// rcps_merge and the assertion macro header.
`timescale 1ns / 1ps
`include "rc_pulse_capture_smoother_assert.svh"

module rc_pulse_capture_smoother import rcps_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int AVG_LEN  = AVG_LEN_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // pin_levels, time_now
    input  logic                  s_tuser,   // mode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // channel, smoothed_width, good_mask, all_good
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int HIST_DEPTH = AVG_LEN - 1;
    localparam int SLOT_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int IDX_W      = $clog2(CHANNELS);

    state_e             state_reg, state_next;
    mode_e              mode_reg;
    logic [PIN_W-1:0]   prev_pins_reg;
    logic [PIN_W-1:0]   pins_reg;
    logic [PIN_W-1:0]   changed_reg;
    logic [TIME_W-1:0]  time_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [SLOT_W-1:0]  slot_next;
    logic [IDX_W-1:0]   idx_reg;
    cfg_t               cfg_reg;
    lane_ctl_t          ctl;
    logic               accept;
    logic               out_free;
    logic [CHANNELS-1:0] lane_hit;
    logic [PULSE_W-1:0] lane_sm [CHANNELS];

    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid || m_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold  <= THRESHOLD_RST;
            cfg_reg.timer_wrap <= WRAP_RST;
            cfg_reg.min_pulse  <= MIN_PULSE_RST;
            cfg_reg.max_pulse  <= MAX_PULSE_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_THRESHOLD:  cfg_reg.threshold  <= cfg_data[PULSE_W-1:0];
                REG_TIMER_WRAP: cfg_reg.timer_wrap <= cfg_data[TIME_W-1:0];
                REG_MIN_PULSE:  cfg_reg.min_pulse  <= cfg_data[PULSE_W-1:0];
                REG_MAX_PULSE:  cfg_reg.max_pulse  <= cfg_data[PULSE_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_FETCH;
            ST_FETCH:  state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_SETTLE;
            ST_SETTLE: state_next = ST_EMIT;
            ST_EMIT:   if (out_free && ctl.last) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_tready    = 1'b0;
        ctl.mode    = mode_reg;
        ctl.stage_a = 1'b0;
        ctl.stage_b = 1'b0;
        ctl.stage_c = 1'b0;
        ctl.load    = 1'b0;
        ctl.last    = (mode_reg == MODE_SAMPLE) || (idx_reg == IDX_W'(CHANNELS - 1));
        unique case (state_reg)
            ST_IDLE:   s_tready    = 1'b1;
            ST_FETCH:  ctl.stage_a = 1'b1;
            ST_UPDATE: ctl.stage_b = 1'b1;
            ST_SETTLE: ctl.stage_c = 1'b1;
            ST_EMIT:   ctl.load    = out_free;
            default: ;
        endcase
    end

    // History slot advances before use and cycles through the history depth.
    assign slot_next = (slot_reg == SLOT_W'(HIST_DEPTH - 1)) ? '0 : slot_reg + SLOT_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            prev_pins_reg <= '0;
            slot_reg      <= '0;
            idx_reg       <= '0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                idx_reg <= '0;
                if (mode_e'(s_tuser) == MODE_SAMPLE) begin
                    prev_pins_reg <= s_tdata[PIN_W-1:0];
                end
            end else if (ctl.load) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (ctl.stage_a && mode_reg == MODE_TICK) begin
                slot_reg <= slot_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg    <= mode_e'(s_tuser);
            pins_reg    <= s_tdata[PIN_W-1:0];
            time_reg    <= s_tdata[PIN_W +: TIME_W];
            changed_reg <= s_tdata[PIN_W-1:0] ^ prev_pins_reg;
        end
    end

    for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
        rcps_lane #(
            .AVG_LEN (AVG_LEN)
        ) u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl),
            .cfg       (cfg_reg),
            .slot      (slot_reg),
            .main_lane (i < MAIN_LANES),
            .pin       (pins_reg[i]),
            .changed   (changed_reg[i]),
            .time_now  (time_reg),
            .good_hit  (lane_hit[i]),
            .smoothed  (lane_sm[i])
        );
    end

    rcps_merge #(
        .CHANNELS (CHANNELS)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .idx       (idx_reg),
        .good_hits (lane_hit[MAIN_LANES-1:0]),
        .smoothed  (lane_sm),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    `RCPS_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, accept, !s_tready)
    `RCPS_ASSERT_IMP(a_mask_never_full, aclk, aresetn, m_tvalid,
        m_tdata[18:15] != GOOD_ALL)
    `RCPS_ASSERT_IMP(a_all_good_clears, aclk, aresetn, m_tvalid && m_tdata[19],
        m_tdata[18:15] == '0 && m_tlast)
    `RCPS_ASSERT_IMP(a_slot_in_range, aclk, aresetn, 1'b1, slot_reg < HIST_DEPTH)

endmodule

// File: sv/rcps_lane.sv
// One channel lane: edge timing, width window check and smoothing.
// Depends on rcps_pkg; instantiated once per channel by the top level.
`timescale 1ns / 1ps

module rcps_lane import rcps_pkg::*; #(
    parameter int AVG_LEN = AVG_LEN_DEF,
    localparam int HIST_DEPTH = AVG_LEN - 1,
    localparam int SLOT_W = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  lane_ctl_t          ctl,
    input  cfg_t               cfg,
    input  logic [SLOT_W-1:0]  slot,
    input  logic               main_lane,
    input  logic               pin,
    input  logic               changed,
    input  logic [TIME_W-1:0]  time_now,
    output logic               good_hit,
    output logic [PULSE_W-1:0] smoothed
);

    localparam int SUM_W       = PULSE_W + $clog2(AVG_LEN);
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + AVG_LEN - 1) / AVG_LEN;
    localparam int PROD_W      = SUM_W + RECIP_SHIFT;

    logic [TIME_W-1:0]  rise_reg;
    logic [TIME_W-1:0]  acc_reg;
    logic [PULSE_W-1:0] raw_reg;
    logic [PULSE_W-1:0] sm_reg;
    logic [PULSE_W-1:0] sm_next;
    logic [PULSE_W-1:0] mean_reg;
    logic [PULSE_W-1:0] hist_reg [HIST_DEPTH];

    logic [SUM_W-1:0]   sum;
    logic [TIME_W-1:0]  wrap_add;
    logic [TIME_W-1:0]  width;
    logic [PROD_W-1:0]  prod;
    logic               fit;
    logic               qualify;
    logic [PULSE_W:0]   up_limit;

    // Rounded sum of the raw width and its history.
    always_comb begin
        sum = SUM_W'(raw_reg) + SUM_W'(AVG_LEN / 2);
        for (int j = 0; j < HIST_DEPTH; j++) begin
            sum = sum + SUM_W'(hist_reg[j]);
        end
    end

    // Width modulo 2^16; add the wrap amount when the counter rolled over.
    assign wrap_add = (rise_reg > time_now) ? cfg.timer_wrap : '0;
    assign width    = time_now + wrap_add - rise_reg;

    assign prod = PROD_W'(acc_reg[SUM_W-1:0]) * PROD_W'(RECIP);

    assign fit = changed && !pin
              && (acc_reg > TIME_W'(cfg.min_pulse))
              && (acc_reg < TIME_W'(cfg.max_pulse));

    assign good_hit = ctl.stage_b && (ctl.mode == MODE_SAMPLE) && fit && main_lane
                   && (acc_reg > TIME_W'(cfg.threshold));

    assign qualify  = (raw_reg > cfg.threshold) || !main_lane;
    assign up_limit = (PULSE_W + 1)'(sm_reg) + (PULSE_W + 1)'(3);

    // Deadband: move only when the mean leaves +-3, to within 2 of it.
    always_comb begin
        sm_next = sm_reg;
        if (sm_reg >= PULSE_W'(3) && mean_reg < sm_reg - PULSE_W'(3)) begin
            sm_next = mean_reg + PULSE_W'(2);
        end
        if ((PULSE_W + 1)'(mean_reg) > up_limit) begin
            sm_next = mean_reg - PULSE_W'(2);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rise_reg <= '0;
            raw_reg  <= WIDTH_RST;
            sm_reg   <= WIDTH_RST;
            for (int j = 0; j < HIST_DEPTH; j++) begin
                hist_reg[j] <= '0;
            end
        end else begin
            if (ctl.stage_a && ctl.mode == MODE_SAMPLE && changed && pin) begin
                rise_reg <= time_now;
            end
            if (ctl.stage_b && ctl.mode == MODE_SAMPLE && fit) begin
                raw_reg <= acc_reg[PULSE_W-1:0];
            end
            if (ctl.stage_c && ctl.mode == MODE_TICK && qualify) begin
                sm_reg <= sm_next;
                for (int j = 0; j < HIST_DEPTH; j++) begin
                    if (slot == SLOT_W'(j)) begin
                        hist_reg[j] <= raw_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.stage_a) begin
            acc_reg <= (ctl.mode == MODE_SAMPLE) ? width : TIME_W'(sum);
        end
        if (ctl.stage_b && ctl.mode == MODE_TICK) begin
            mean_reg <= prod[RECIP_SHIFT +: PULSE_W];
        end
    end

    assign smoothed = sm_reg;

endmodule

// File: sv/rcps_merge.sv
// Merge stage: combines lane good bits and drives the result register.
// Depends on rcps_pkg; instantiated by the top level.
`timescale 1ns / 1ps

module rcps_merge import rcps_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF,
    localparam int IDX_W = $clog2(CHANNELS)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lane_ctl_t             ctl,
    input  logic [IDX_W-1:0]      idx,
    input  logic [MAIN_LANES-1:0] good_hits,
    input  logic [PULSE_W-1:0]    smoothed [CHANNELS],
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [OUT_DATA_W-1:0] m_tdata,   // channel, smoothed_width, good_mask, all_good
    output logic                  m_tlast
);

    logic [GOOD_W-1:0]     good_reg;
    logic [GOOD_W-1:0]     good_next;
    logic                  all_good_reg;
    logic                  valid_reg;
    logic [OUT_DATA_W-1:0] data_reg;
    logic                  last_reg;
    logic [CH_W-1:0]       ch_field;
    logic [PULSE_W-1:0]    sw_field;
    logic                  ag_field;

    assign good_next = good_reg | good_hits;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            good_reg     <= '0;
            all_good_reg <= 1'b0;
        end else if (ctl.stage_b && ctl.mode == MODE_SAMPLE) begin
            // All four main channels good: report once and start over.
            if (good_next == GOOD_ALL) begin
                good_reg     <= '0;
                all_good_reg <= 1'b1;
            end else begin
                good_reg     <= good_next;
                all_good_reg <= 1'b0;
            end
        end
    end

    assign ch_field = (ctl.mode == MODE_TICK) ? CH_W'(idx) : '0;
    assign sw_field = (ctl.mode == MODE_TICK) ? smoothed[idx] : '0;
    assign ag_field = (ctl.mode == MODE_SAMPLE) ? all_good_reg : 1'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl.load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            data_reg <= {4'b0, ag_field, good_reg, sw_field, ch_field};
            last_reg <= ctl.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

// File: test/rc_pulse_capture_smoother_tb.sv
// Self-checking testbench for rc_pulse_capture_smoother: pin samples and compute ticks
// are checked field by field against a cycle-free predictor. Depends on rcps_pkg and the DUT.
`timescale 1ns / 1ps

module rc_pulse_capture_smoother_tb;
    import rcps_pkg::*;

    localparam int NCH           = CHANNELS_DEF;
    localparam int HIST          = AVG_LEN_DEF - 1;
    localparam int SETTLE_CYCLES = 16;
    localparam int PLAN_LEN      = 22;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 75;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'hF;

    typedef enum logic {
        ROW_ITEM,
        ROW_REG
    } row_kind_e;

    typedef struct packed {
        row_kind_e             kind;
        mode_e                 mode;
        logic [PIN_W-1:0]      pins;
        logic [TIME_W-1:0]     stamp;
        logic                  typed;
        logic [GOOD_W-1:0]     good;
        logic                  all_good;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
    } plan_row_t;

    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic [PULSE_W-1:0] width;
        logic [GOOD_W-1:0]  good;
        logic               all_good;
        logic               last;
    } width_report_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor copy of configuration and state
    logic [PULSE_W-1:0] cfg_threshold;
    logic [TIME_W-1:0]  cfg_wrap;
    logic [PULSE_W-1:0] cfg_min;
    logic [PULSE_W-1:0] cfg_max;
    logic [PIN_W-1:0]   pins_seen;
    logic [TIME_W-1:0]  rise_at [NCH];
    logic [PULSE_W-1:0] raw_width [NCH];
    logic [PULSE_W-1:0] smooth_width [NCH];
    logic [PULSE_W-1:0] width_hist [NCH][HIST];
    int unsigned        hist_slot;
    logic [GOOD_W-1:0]  good_bits;

    width_report_t reports_due [$];
    int unsigned   mismatches = 0;
    bit            steady = 1'b0;

    // Pin stimulus bookkeeping
    logic [PIN_W-1:0]  gen_pins = '0;
    logic [TIME_W-1:0] gen_rise [NCH];

    plan_row_t plan [PLAN_LEN];

    rc_pulse_capture_smoother DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("rc_pulse_capture_smoother: mismatch");
        $finish;
    end

    function automatic int unsigned draw_gap();
        return steady ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic plan_row_t sample_row(logic [PIN_W-1:0] pins, logic [TIME_W-1:0] stamp,
                                             logic [GOOD_W-1:0] good, logic all_good);
        return '{ROW_ITEM, MODE_SAMPLE, pins, stamp, 1'b1, good, all_good, REG_THRESHOLD, '0};
    endfunction

    function automatic plan_row_t tick_row(logic [PIN_W-1:0] pins, logic [TIME_W-1:0] stamp);
        return '{ROW_ITEM, MODE_TICK, pins, stamp, 1'b0, '0, 1'b0, REG_THRESHOLD, '0};
    endfunction

    function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
        return '{ROW_REG, MODE_SAMPLE, '0, '0, 1'b0, '0, 1'b0, idx, data};
    endfunction

    task automatic reset_model();
        cfg_threshold = THRESHOLD_RST;
        cfg_wrap      = WRAP_RST;
        cfg_min       = MIN_PULSE_RST;
        cfg_max       = MAX_PULSE_RST;
        pins_seen     = '0;
        hist_slot     = 0;
        good_bits     = '0;
        for (int i = 0; i < NCH; i++) begin
            rise_at[i]      = '0;
            raw_width[i]    = WIDTH_RST;
            smooth_width[i] = WIDTH_RST;
            gen_rise[i]     = '0;
            for (int a = 0; a < HIST; a++) width_hist[i][a] = '0;
        end
    endtask

    task automatic apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_THRESHOLD:  cfg_threshold = data[PULSE_W-1:0];
            REG_TIMER_WRAP: cfg_wrap      = data;
            REG_MIN_PULSE:  cfg_min       = data[PULSE_W-1:0];
            REG_MAX_PULSE:  cfg_max       = data[PULSE_W-1:0];
            default: ;
        endcase
    endtask

    // Expected reports for one accepted item
    task automatic capture_and_smooth(mode_e mode, logic [PIN_W-1:0] pins,
                                      logic [TIME_W-1:0] stamp);
        logic [PIN_W-1:0] changed;
        int unsigned      rise, span, mean, cur;
        logic             cleared;
        width_report_t    rep;
        if (mode == MODE_SAMPLE) begin
            changed   = pins ^ pins_seen;
            pins_seen = pins;
            cleared   = 1'b0;
            for (int i = 0; i < NCH; i++) begin
                if (changed[i]) begin
                    if (pins[i]) begin
                        rise_at[i] = stamp;
                    end else begin
                        rise = 32'(rise_at[i]);
                        if (rise > stamp)
                            span = (stamp + cfg_wrap - rise) & 32'hFFFF;
                        else
                            span = stamp - rise;
                        if (span > cfg_min && span < cfg_max) begin
                            raw_width[i] = span[PULSE_W-1:0];
                            if (i < MAIN_LANES && span > cfg_threshold) good_bits[i] = 1'b1;
                        end
                    end
                end
            end
            if (good_bits == GOOD_ALL) begin
                good_bits = '0;
                cleared   = 1'b1;
            end
            rep = '{'0, '0, good_bits, cleared, 1'b1};
            reports_due.push_back(rep);
        end else begin
            hist_slot++;
            if (hist_slot >= HIST) hist_slot = 0;
            for (int ch = 0; ch < NCH; ch++) begin
                if (raw_width[ch] > cfg_threshold || ch >= MAIN_LANES) begin
                    mean = 32'(raw_width[ch]);
                    for (int a = 0; a < HIST; a++) mean += 32'(width_hist[ch][a]);
                    mean = (mean + AVG_LEN_DEF / 2) / AVG_LEN_DEF;
                    cur  = 32'(smooth_width[ch]);
                    // no wrap below zero: a value under 3 never moves down
                    if (cur >= 3 && mean < cur - 3) cur = mean + 2;
                    if (mean > smooth_width[ch] + 3) cur = mean - 2;
                    smooth_width[ch] = cur[PULSE_W-1:0];
                    width_hist[ch][hist_slot] = raw_width[ch];
                end
                rep = '{ch[CH_W-1:0], smooth_width[ch], good_bits, 1'b0, ch == NCH - 1};
                reports_due.push_back(rep);
            end
        end
    endtask

    // Enter and leave on a falling edge; valid stays high for a back-to-back item
    task automatic send_item(mode_e mode, logic [PIN_W-1:0] pins, logic [TIME_W-1:0] stamp);
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {stamp, pins};
        s_tuser  <= mode;
        do @(posedge aclk); while (!s_tready);
        capture_and_smooth(mode, pins, stamp);
        @(negedge aclk);
    endtask

    // Hold the sender until every report is in, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (reports_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic retune(logic [CFG_DATA_W-1:0] thr, logic [CFG_DATA_W-1:0] wrap,
                          logic [CFG_DATA_W-1:0] lo, logic [CFG_DATA_W-1:0] hi);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_TIMER_WRAP, wrap);
        write_reg(REG_MIN_PULSE, lo);
        write_reg(REG_MAX_PULSE, hi);
    endtask

    // Mostly clean rise/fall pairs with widths around the window, plus ticks and noise
    task automatic random_item();
        int unsigned      roll, period, c, lo, hi, span;
        logic [PIN_W-1:0] pins;
        logic [TIME_W-1:0] stamp;
        roll   = $urandom_range(0, 99);
        period = (cfg_wrap == 0) ? 65536 : 32'(cfg_wrap);
        if (roll < 15) begin
            send_item(MODE_TICK, PIN_W'($urandom_range(0, 255)),
                      TIME_W'($urandom_range(0, 65535)));
        end else if (roll < 25) begin
            pins = PIN_W'($urandom_range(0, 255));
            send_item(MODE_SAMPLE, pins, TIME_W'($urandom_range(0, 65535)));
            gen_pins = pins;
        end else begin
            c    = $urandom_range(0, NCH - 1);
            pins = gen_pins ^ (8'h01 << c);
            if (gen_pins[c]) begin
                lo = (cfg_min > 40) ? cfg_min - 40 : 0;
                hi = (cfg_max + 40 > 4095) ? 4095 : cfg_max + 40;
                if (lo > hi) begin
                    lo = 0;
                    hi = 4095;
                end
                span  = $urandom_range(lo, hi);
                stamp = TIME_W'((gen_rise[c] + span) % period);
            end else begin
                stamp       = TIME_W'($urandom_range(0, period - 1));
                gen_rise[c] = stamp;
            end
            send_item(MODE_SAMPLE, pins, stamp);
            gen_pins = pins;
        end
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        width_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (reports_due.size() == 0) begin
                $error("unexpected report: tdata %h tlast %b", m_tdata, m_tlast);
                mismatches++;
            end else begin
                want = reports_due.pop_front();
                check_field("channel", 32'(want.channel), 32'(m_tdata[CH_W-1:0]));
                check_field("smoothed_width", 32'(want.width), 32'(m_tdata[CH_W +: PULSE_W]));
                check_field("good_mask", 32'(want.good),
                            32'(m_tdata[CH_W+PULSE_W +: GOOD_W]));
                check_field("all_good", 32'(want.all_good),
                            32'(m_tdata[CH_W+PULSE_W+GOOD_W]));
                check_field("last", 32'(want.last), 32'(m_tlast));
            end
        end
    end

    // Result side: random stall before each report, none while steady
    initial begin
        int unsigned gap;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    initial begin
        plan = '{
            sample_row(8'hFF, 16'd100,   4'h0, 1'b0),  // all pins rise
            sample_row(8'hFE, 16'd1600,  4'h1, 1'b0),
            sample_row(8'hFC, 16'd1100,  4'h3, 1'b0),
            sample_row(8'hF8, 16'd1000,  4'h3, 1'b0),  // width equal to min: dropped
            sample_row(8'hF0, 16'd2300,  4'h3, 1'b0),  // width equal to max: dropped
            sample_row(8'hFF, 16'd3000,  4'h3, 1'b0),
            sample_row(8'hF0, 16'd4000,  4'h0, 1'b1),  // four good channels clear
            sample_row(8'hF1, 16'd9500,  4'h0, 1'b0),
            sample_row(8'hF0, 16'd500,   4'h1, 1'b0),  // timestamp wrapped, width 999
            sample_row(8'h00, 16'd2000,  4'h1, 1'b0),  // upper channels never set good
            sample_row(8'h80, 16'hFFFF,  4'h1, 1'b0),
            sample_row(8'h00, 16'h0000,  4'h1, 1'b0),  // wrapped width outside window
            reg_row(REG_MIN_PULSE, 16'd0),
            sample_row(8'h20, 16'd200,   4'h1, 1'b0),
            sample_row(8'h00, 16'd201,   4'h1, 1'b0),  // one-microsecond pulse
            tick_row(8'h00, 16'h0000),                 // smoothed value drops under 3
            tick_row(8'hA5, 16'hFFFF),
            tick_row(8'h5A, 16'h1234),
            reg_row(REG_UNMAPPED, 16'hFFFF),
            reg_row(REG_THRESHOLD, 16'hFFFF),          // main channels stop smoothing
            tick_row(8'h00, 16'h0000),
            reg_row(REG_THRESHOLD, 16'd985)
        };
        reset_model();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_REG) begin
                drain();
                write_reg(plan[r].reg_idx, plan[r].reg_data);
            end else begin
                send_item(plan[r].mode, plan[r].pins, plan[r].stamp);
                if (plan[r].typed)
                    reports_due[reports_due.size()-1] =
                        '{'0, '0, plan[r].good, plan[r].all_good, 1'b1};
            end
        end

        gen_pins = pins_seen;
        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            case (phase)
                0: retune(16'd0, 16'd1, 16'd0, 16'd4095);
                1: retune(16'd4095, 16'hFFFF, 16'd4095, 16'd0);
                2: retune(16'd1200, 16'd20000, 16'd800, 16'd2500);
                4: retune(16'd985, 16'd9999, 16'd900, 16'd2200);
                default: retune(CFG_DATA_W'($urandom_range(0, 65535)),
                                CFG_DATA_W'($urandom_range(0, 65535)),
                                CFG_DATA_W'($urandom_range(0, 65535)),
                                CFG_DATA_W'($urandom_range(0, 65535)));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 25 == 0) steady = ($urandom_range(0, 3) == 0);
                random_item();
            end
        end

        drain();
        if (mismatches == 0)
            $display("rc_pulse_capture_smoother: match");
        else
            $display("rc_pulse_capture_smoother: mismatch");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/rcps_pkg.sv
sv/rcps_lane.sv
sv/rcps_merge.sv
sv/rc_pulse_capture_smoother.sv
test/rc_pulse_capture_smoother_tb.sv
